@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DPHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// consequent must hold in the cycle after the antecedent
`define DPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ hdl/dpht_pkg.sv @@
// shared types and constants of the depth-preferred hash table
// no dependencies; imported by the controller, datapath and top level
package dpht_pkg;

    // table geometry, ENTRIES must be a power of two
    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 16;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 8;
    localparam int KIND_W  = 2;
    localparam int PAY_W   = MOVE_W + SCORE_W + DEPTH_W + KIND_W;
    localparam int SLOT_W  = KEY_W + PAY_W;

    // request codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_PROBE = 1'b1;

    // store outcome codes
    typedef enum logic [1:0] {
        OUT_EMPTY   = 2'd0,
        OUT_SAME    = 2'd1,
        OUT_COLLIDE = 2'd2,
        OUT_REJECT  = 2'd3
    } t_outcome;

    // payload word as laid out in the slot memory
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]  move;
    } t_payload;

    // controller to datapath commands
    typedef struct packed {
        logic             accept;
        logic             finish;
        logic             clr_we;
        logic [IDX_W-1:0] clr_addr;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_blocked;
    } t_dp_status;

endpackage

@@ hdl/depth_preferred_hash_table.sv @@
// top level of the depth-preferred hash table
// depends on dpht_pkg, dpht_ctrl, dpht_datapath
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request per transaction:
//   i_func selects store or probe, i_key is the 64-bit position key, the other
//   fields are the entry to store. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result per request: probe hit and stored fields, or the
//   store outcome (empty written, same key, collision, rejected).
//   A request is latched on accept together with the registered slot memory
//   read; the evaluate step then decides, writes back and loads the result
//   register. No new request is taken until that evaluate step has finished.
//   Reset: a clearing sweep writes zero to all ENTRIES slots, one per cycle;
//   o_in_stall stays high during it.
//   Output stall: the result register holds; the evaluate step of the next
//   request waits until the register is free, so the input stalls behind it.
module depth_preferred_hash_table import dpht_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_func,
    input  logic [KEY_W-1:0]          i_key,
    input  logic [MOVE_W-1:0]         i_move_code,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic [KIND_W-1:0]         i_score_kind,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit,
    output logic [MOVE_W-1:0]         o_found_move,
    output logic signed [SCORE_W-1:0] o_found_score,
    output logic [DEPTH_W-1:0]        o_found_depth,
    output logic [KIND_W-1:0]         o_found_kind,
    output logic [1:0]                o_store_outcome
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing
    dpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // storage and decision
    dpht_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_func          (i_func),
        .i_key           (i_key),
        .i_move_code     (i_move_code),
        .i_score         (i_score),
        .i_search_depth  (i_search_depth),
        .i_score_kind    (i_score_kind),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_found_move    (o_found_move),
        .o_found_score   (o_found_score),
        .o_found_depth   (o_found_depth),
        .o_found_kind    (o_found_kind),
        .o_store_outcome (o_store_outcome)
    );

endmodule

@@ hdl/dpht_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module dpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/dpht_ctrl.sv @@
// controller: clearing sweep after reset, transaction accept and evaluate sequencing
// depends on dpht_pkg
module dpht_ctrl import dpht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_clr_cnt, n_clr_cnt;
    logic             w_accept;
    logic             w_finish;

    assign w_accept = (r_state == ST_IDLE) && i_in_valid;
    assign w_finish = (r_state == ST_EVAL) && !i_status.out_blocked;

    // next state
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd.accept   = w_accept;
        o_cmd.finish   = w_finish;
        o_cmd.clr_we   = (r_state == ST_CLEAR);
        o_cmd.clr_addr = r_clr_cnt;
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

@@ hdl/dpht_datapath.sv @@
// datapath: request registers, slot memory, replacement decision, result register
// depends on dpht_pkg and dpht_ram
module dpht_datapath import dpht_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic                      i_func,
    input  logic [KEY_W-1:0]          i_key,
    input  logic [MOVE_W-1:0]         i_move_code,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic [KIND_W-1:0]         i_score_kind,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit,
    output logic [MOVE_W-1:0]         o_found_move,
    output logic signed [SCORE_W-1:0] o_found_score,
    output logic [DEPTH_W-1:0]        o_found_depth,
    output logic [KIND_W-1:0]         o_found_kind,
    output logic [1:0]                o_store_outcome
);

    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    t_payload          r_new_pay;

    logic [SLOT_W-1:0] w_rd_data;
    logic [KEY_W-1:0]  w_skey;
    t_payload          w_spay;
    logic              w_match;
    t_outcome          w_outcome;

    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [SLOT_W-1:0] w_wr_data;

    logic              r_out_valid;
    logic              r_hit;
    t_payload          r_found;
    t_outcome          r_outcome;

    // latch the request on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func          <= i_func;
            r_key           <= i_key;
            r_new_pay.move  <= i_move_code;
            r_new_pay.score <= i_score;
            r_new_pay.depth <= i_search_depth;
            r_new_pay.kind  <= i_score_kind;
        end
    end

    // slot memory, read issued straight from the input key
    dpht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (i_key[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_skey  = w_rd_data[SLOT_W-1:PAY_W];
    assign w_spay  = t_payload'(w_rd_data[PAY_W-1:0]);
    assign w_match = (w_skey == r_key);

    // depth-preferred replacement decision
    always_comb begin
        if (w_skey == '0) begin
            w_outcome = OUT_EMPTY;
        end else if (w_match) begin
            w_outcome = (w_spay.depth <= r_new_pay.depth) ? OUT_SAME : OUT_REJECT;
        end else begin
            w_outcome = OUT_COLLIDE;
        end
    end

    // write port: clearing sweep or accepted store
    always_comb begin
        if (i_cmd.clr_we) begin
            w_wr_en   = 1'b1;
            w_wr_addr = i_cmd.clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = i_cmd.finish && (r_func == FUNC_STORE) && (w_outcome != OUT_REJECT);
            w_wr_addr = r_key[IDX_W-1:0];
            w_wr_data = {r_key, r_new_pay};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_func == FUNC_PROBE) begin
                r_hit     <= w_match;
                r_found   <= w_match ? w_spay : '0;
                r_outcome <= OUT_EMPTY;
            end else begin
                r_hit     <= 1'b0;
                r_found   <= '0;
                r_outcome <= w_outcome;
            end
        end
    end

    // result valid, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.finish || (r_out_valid && i_out_stall);
        end
    end

    assign o_status.out_blocked = r_out_valid && i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_found_move    = r_found.move;
    assign o_found_score   = r_found.score;
    assign o_found_depth   = r_found.depth;
    assign o_found_kind    = r_found.kind;
    assign o_store_outcome = r_outcome;

endmodule

@@ hdl/dpht_checker.sv @@
// port-level checker for the depth-preferred hash table, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module dpht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_hit,
    input logic [15:0] o_found_move,
    input logic [15:0] o_found_score,
    input logic [7:0]  o_found_depth,
    input logic [1:0]  o_found_kind,
    input logic [1:0]  o_store_outcome
);

    // stalled result holds: valid, hit, move, score and store outcome stay stable
    `DPHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_hit) && $stable(o_found_move) && $stable(o_found_score) && $stable(o_store_outcome))

    // one transaction in flight: busy right after an accept
    `DPHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a miss or a store reports all-zero entry fields
    `DPHT_ASSERT(a_miss_zero, i_clk, i_rst_n, !(o_out_valid && !o_hit) || (o_found_move == 16'd0 && o_found_score == 16'd0 && o_found_depth == 8'd0 && o_found_kind == 2'd0))

    // a hit never carries a store outcome
    `DPHT_ASSERT(a_hit_no_outcome, i_clk, i_rst_n, !(o_out_valid && o_hit) || o_store_outcome == 2'd0)

endmodule

bind depth_preferred_hash_table dpht_checker u_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the depth-preferred hash table
// depends on dpht_pkg and depth_preferred_hash_table; keeps its own copy of the table

module tb import dpht_pkg::*;;

    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int RANDOM_PER_PHASE = 470;
    localparam int POOL_SIZE        = 32;
    localparam int POOL_SLOTS       = 8;
    localparam int N_PHASES         = 4;

    // sender idle and receiver stall chances per phase, percent
    localparam int PHASE_IDLE  [N_PHASES] = '{0, 73, 0, 19};
    localparam int PHASE_STALL [N_PHASES] = '{0, 0, 73, 19};

    typedef struct packed {
        logic                      func;
        logic [KEY_W-1:0]          key;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [KIND_W-1:0]         kind;
    } t_request;

    typedef struct packed {
        logic                      hit;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [KIND_W-1:0]         kind;
        t_outcome                  outcome;
    } t_lookup;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_lookup  want;
    } t_row;

    // keys for the directed part: two keys sharing slot 3, an alias of slot 0, all ones
    localparam logic [KEY_W-1:0] KEY_A     = 64'h8000_0000_0000_0003;
    localparam logic [KEY_W-1:0] KEY_B     = 64'h7fff_ffff_ffff_fc03;
    localparam logic [KEY_W-1:0] KEY_ALIAS = 64'h0000_0000_0000_0400;
    localparam logic [KEY_W-1:0] KEY_ONES  = 64'hffff_ffff_ffff_ffff;

    localparam t_lookup NO_HIT    = '{1'b0, 16'h0, 16'sh0, 8'h0, 2'd0, OUT_EMPTY};
    localparam t_lookup ZERO_HIT  = '{1'b1, 16'h0, 16'sh0, 8'h0, 2'd0, OUT_EMPTY};
    localparam t_lookup A_HIT     = '{1'b1, 16'hffff, 16'sh8000, 8'hff, 2'd3, OUT_EMPTY};
    localparam t_lookup B_HIT     = '{1'b1, 16'h0, 16'sh7fff, 8'h0, 2'd0, OUT_EMPTY};
    localparam t_lookup W_EMPTY   = '{1'b0, 16'h0, 16'sh0, 8'h0, 2'd0, OUT_EMPTY};
    localparam t_lookup W_SAME    = '{1'b0, 16'h0, 16'sh0, 8'h0, 2'd0, OUT_SAME};
    localparam t_lookup W_COLLIDE = '{1'b0, 16'h0, 16'sh0, 8'h0, 2'd0, OUT_COLLIDE};
    localparam t_lookup W_REJECT  = '{1'b0, 16'h0, 16'sh0, 8'h0, 2'd0, OUT_REJECT};

    // directed stimulus; rows with typed clear are checked against the predictor
    localparam int N_DIRECTED = 24;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{FUNC_PROBE, 64'h5, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, NO_HIT},
        '{'{FUNC_PROBE, 64'h0, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, ZERO_HIT},
        '{'{FUNC_STORE, KEY_A, 16'hffff, 16'sh8000, 8'hff, 2'd3}, 1'b1, W_EMPTY},
        '{'{FUNC_PROBE, KEY_A, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, A_HIT},
        '{'{FUNC_STORE, KEY_A, 16'h1111, 16'sh0001, 8'hfe, 2'd1}, 1'b1, W_REJECT},
        '{'{FUNC_PROBE, KEY_A, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, A_HIT},
        '{'{FUNC_STORE, KEY_A, 16'h2222, 16'sh7fff, 8'hff, 2'd2}, 1'b1, W_SAME},
        '{'{FUNC_STORE, KEY_B, 16'h0, 16'sh7fff, 8'h0, 2'd0}, 1'b1, W_COLLIDE},
        '{'{FUNC_PROBE, KEY_A, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, NO_HIT},
        '{'{FUNC_PROBE, KEY_B, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, B_HIT},
        '{'{FUNC_STORE, KEY_B, 16'habcd, 16'sh8001, 8'h0, 2'd1}, 1'b1, W_SAME},
        '{'{FUNC_STORE, 64'h0, 16'h1234, 16'sh5678, 8'h9, 2'd2}, 1'b1, W_EMPTY},
        '{'{FUNC_PROBE, 64'h0, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b0, NO_HIT},
        '{'{FUNC_STORE, 64'h0, 16'h4321, 16'sh0, 8'h3, 2'd1}, 1'b1, W_EMPTY},
        '{'{FUNC_PROBE, KEY_ALIAS, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, NO_HIT},
        '{'{FUNC_STORE, KEY_ALIAS, 16'h5555, 16'sh0, 8'h7, 2'd3}, 1'b1, W_EMPTY},
        '{'{FUNC_PROBE, 64'h0, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b1, NO_HIT},
        '{'{FUNC_STORE, KEY_ONES, 16'haaaa, 16'sh8000, 8'h80, 2'd0}, 1'b1, W_EMPTY},
        '{'{FUNC_PROBE, KEY_ONES, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b0, NO_HIT},
        '{'{FUNC_STORE, KEY_ONES, 16'h5555, 16'sh7fff, 8'h7f, 2'd1}, 1'b1, W_REJECT},
        '{'{FUNC_STORE, KEY_ONES, 16'h5a5a, 16'sh0, 8'h80, 2'd2}, 1'b1, W_SAME},
        '{'{FUNC_PROBE, KEY_ALIAS, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b0, NO_HIT},
        '{'{FUNC_STORE, KEY_A, 16'h0f0f, 16'shff00, 8'h1, 2'd1}, 1'b1, W_COLLIDE},
        '{'{FUNC_PROBE, KEY_A, 16'h0, 16'sh0, 8'h0, 2'd0}, 1'b0, NO_HIT}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_func;
    logic [KEY_W-1:0]          i_key;
    logic [MOVE_W-1:0]         i_move_code;
    logic signed [SCORE_W-1:0] i_score;
    logic [DEPTH_W-1:0]        i_search_depth;
    logic [KIND_W-1:0]         i_score_kind;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_hit;
    logic [MOVE_W-1:0]         o_found_move;
    logic signed [SCORE_W-1:0] o_found_score;
    logic [DEPTH_W-1:0]        o_found_depth;
    logic [KIND_W-1:0]         o_found_kind;
    logic [1:0]                o_store_outcome;

    // shadow copy of the slot memory
    logic [KEY_W-1:0] tt_keys [ENTRIES];
    t_payload         tt_pays [ENTRIES];

    // keys crowded onto a few slots so same-key and collision cases are common
    logic [KEY_W-1:0] key_pool  [POOL_SIZE];
    logic [IDX_W-1:0] pool_slot [POOL_SLOTS];

    t_lookup pending_results [$];

    int send_idle_pct;
    int stall_pct;
    int err_count;
    int idle_cycles;
    int n_store;
    int n_probe;
    int n_hit;
    int outcome_seen [4];

    depth_preferred_hash_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_move_code    (i_move_code),
        .i_score        (i_score),
        .i_search_depth (i_search_depth),
        .i_score_kind   (i_score_kind),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_found_move   (o_found_move),
        .o_found_score  (o_found_score),
        .o_found_depth  (o_found_depth),
        .o_found_kind   (o_found_kind),
        .o_store_outcome(o_store_outcome)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // probe or store against the shadow table, returning the expected result
    function automatic t_lookup tt_access(input t_request r);
        logic [IDX_W-1:0] slot;
        t_payload         pay;
        t_lookup          res;
        slot = r.key[IDX_W-1:0];
        pay  = tt_pays[slot];
        res  = '0;
        if (r.func == FUNC_PROBE) begin
            if (tt_keys[slot] == r.key) begin
                res.hit   = 1'b1;
                res.move  = pay.move;
                res.score = pay.score;
                res.depth = pay.depth;
                res.kind  = pay.kind;
            end
        end else begin
            if (tt_keys[slot] == '0) begin
                res.outcome = OUT_EMPTY;
            end else if (tt_keys[slot] != r.key) begin
                res.outcome = OUT_COLLIDE;
            end else if (pay.depth <= r.depth) begin
                res.outcome = OUT_SAME;
            end else begin
                res.outcome = OUT_REJECT;
            end
            if (res.outcome != OUT_REJECT) begin
                tt_keys[slot] = r.key;
                tt_pays[slot] = '{kind: r.kind, depth: r.depth, score: r.score, move: r.move};
            end
        end
        return res;
    endfunction

    // mostly pool keys, some fully random keys, a few zero keys
    function automatic t_request random_request();
        t_request    r;
        int          pick;
        logic [31:0] rnd;
        pick   = $urandom_range(0, 99);
        rnd    = $urandom;
        r.func = ($urandom_range(0, 99) < 45) ? FUNC_STORE : FUNC_PROBE;
        if (pick < 75) begin
            r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 97) begin
            r.key = {$urandom, $urandom};
        end else begin
            r.key = '0;
        end
        r.move  = rnd[15:0];
        r.score = rnd[31:16];
        rnd     = $urandom;
        r.kind  = rnd[9:8];
        case ($urandom_range(0, 9))
            0: r.depth = '0;
            1: r.depth = '1;
            default: r.depth = rnd[7:0];
        endcase
        return r;
    endfunction

    // present one transaction, hold it until accepted, then record what it should return
    task automatic send_request(input t_request r, input logic typed, input t_lookup want);
        t_lookup exp_res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= r.func;
        i_key          <= r.key;
        i_move_code    <= r.move;
        i_score        <= r.score;
        i_search_depth <= r.depth;
        i_score_kind   <= r.kind;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        exp_res = tt_access(r);
        if (typed) exp_res = want;
        pending_results = {pending_results, exp_res};
        if (r.func == FUNC_STORE) begin
            n_store++;
            outcome_seen[exp_res.outcome]++;
        end else begin
            n_probe++;
        end
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall and result check
    always @(posedge i_clk) begin : result_check
        t_lookup want;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, nothing outstanding");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, o_hit);
                    err_count++;
                end
                if (o_found_move !== want.move) begin
                    $error("found_move: expected %0h, actual %0h", want.move, o_found_move);
                    err_count++;
                end
                if (o_found_score !== want.score) begin
                    $error("found_score: expected %0d, actual %0d", want.score, o_found_score);
                    err_count++;
                end
                if (o_found_depth !== want.depth) begin
                    $error("found_depth: expected %0d, actual %0d", want.depth, o_found_depth);
                    err_count++;
                end
                if (o_found_kind !== want.kind) begin
                    $error("found_kind: expected %0d, actual %0d", want.kind, o_found_kind);
                    err_count++;
                end
                if (o_store_outcome !== want.outcome) begin
                    $error("store_outcome: expected %0d, actual %0d",
                           want.outcome, o_store_outcome);
                    err_count++;
                end
                if (want.hit) n_hit++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog, no transaction for %0d cycles", idle_cycles);
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        logic [31:0] rnd;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_func         <= FUNC_STORE;
        i_key          <= '0;
        i_move_code    <= '0;
        i_score        <= '0;
        i_search_depth <= '0;
        i_score_kind   <= '0;
        i_out_stall    <= 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        err_count      = 0;
        n_store        = 0;
        n_probe        = 0;
        n_hit          = 0;
        foreach (outcome_seen[i]) outcome_seen[i] = 0;
        foreach (tt_keys[i]) begin
            tt_keys[i] = '0;
            tt_pays[i] = '0;
        end
        foreach (pool_slot[i]) begin
            rnd          = $urandom;
            pool_slot[i] = rnd[IDX_W-1:0];
        end
        foreach (key_pool[i]) begin
            key_pool[i]            = {$urandom, $urandom};
            key_pool[i][IDX_W-1:0] = pool_slot[i % POOL_SLOTS];
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, free-running handshake
        foreach (DIRECTED[i]) begin
            send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
        end
        drain();

        // random part, one pass per idling phase
        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct = PHASE_IDLE[ph];
            stall_pct     = PHASE_STALL[ph];
            repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, NO_HIT);
            drain();
        end
        stall_pct = 0;
        repeat (4) @(posedge i_clk);

        $display("tb: %0d stores, %0d probes with %0d hits; stores: %0d empty, %0d same key,",
                 n_store, n_probe, n_hit, outcome_seen[OUT_EMPTY], outcome_seen[OUT_SAME]);
        $display("tb: %0d collisions, %0d rejected, over four sender/receiver idling phases",
                 outcome_seen[OUT_COLLIDE], outcome_seen[OUT_REJECT]);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
